[hw/rtl/mpql_pkg.sv]
// Package: types, codes and defaults for the linear-scan max priority queue.
package mpql_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int PAYLOAD_W     = 32;
   localparam int SCORE_W       = 16;
   localparam int OCC_W         = 8;
   localparam int ENTRY_W       = PAYLOAD_W + SCORE_W;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 56;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_REMOVED  = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/mpql_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpql_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/max_priority_queue_linear.sv]
// Top level: bounded max priority queue in insertion order, linear scan and shift.
//
//   channel | dir | transaction
//   req_*   | in  | insert (payload, score) or remove highest score
//   rsp_*   | out | status, removed payload and score, occupancy
//
// Insert and empty remove: result registered at the accept edge.
// Remove: a scan of every entry on the RAM read port, then a shift of the
// entries behind the best one down by one place (none when the last entry
// wins), then a finish state that loads the result.
// Reset is synchronous and empties the queue; no clearing pass.
// req_tready is low during a remove and while an undelivered result stalls.
module max_priority_queue_linear #(
   parameter int DEPTH = mpql_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mpql_pkg::REQ_DATA_W-1:0] req_tdata,  // payload[31:0], score[47:32]
   input  logic                            req_tuser,  // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mpql_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_payload, out_score, occupancy
   output logic [1:0]                      rsp_tuser   // status
);
   import mpql_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pv_ff, pv_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] best_pos_ff, best_pos_in;
   logic [PAYLOAD_W-1:0] best_pay_ff, best_pay_in;
   logic signed [SCORE_W-1:0] best_score_ff, best_score_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0]      rsp_pay_ff, rsp_pay_in;
   logic [SCORE_W-1:0]        rsp_score_ff, rsp_score_in;
   logic [OCC_W-1:0]          rsp_occ_ff, rsp_occ_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic                      rsp_free;
   logic                      req_fire;
   logic                      issue;
   logic                      take;
   logic signed [SCORE_W-1:0] rd_score;

   mpql_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_score   = $signed(rd_data[ENTRY_W-1:PAYLOAD_W]);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign issue      = idx_ff < cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      best_pos_ff   <= best_pos_in;
      best_pay_ff   <= best_pay_in;
      best_score_ff <= best_score_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pv_in         = 1'b0;
      pos_in        = pos_ff;
      best_pos_in   = best_pos_ff;
      best_pay_in   = best_pay_ff;
      best_score_in = best_score_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[AW-1:0];
      wr_data       = {req_tdata[REQ_DATA_W-1:PAYLOAD_W], req_tdata[PAYLOAD_W-1:0]};
      rd_addr       = idx_ff[AW-1:0];
      take          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_pay_in   = '0;
               rsp_score_in = '0;
               rsp_occ_in   = OCC_W'(cnt_ff);
               if (kind_type'(req_tuser) == KIND_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (cnt_ff >= DEPTH_C) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     cnt_in        = cnt_ff + 1'b1;
                     rsp_occ_in    = OCC_W'(cnt_ff + 1'b1);
                     rsp_status_in = STATUS_INSERTED;
                  end
               end else if (cnt_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               pv_in  = 1'b1;
               pos_in = idx_ff[AW-1:0];
               idx_in = idx_ff + 1'b1;
            end
            if (pv_ff) begin
               take = (pos_ff == '0) || (rd_score > best_score_ff);
               if (take) begin
                  best_pos_in   = pos_ff;
                  best_pay_in   = rd_data[PAYLOAD_W-1:0];
                  best_score_in = rd_score;
               end
               if (CW'(pos_ff) + 1'b1 == cnt_ff) begin
                  pv_in    = 1'b0;
                  idx_in   = CW'(best_pos_in) + 1'b1;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (issue) begin
               pv_in  = 1'b1;
               pos_in = idx_ff[AW-1:0];
               idx_in = idx_ff + 1'b1;
            end
            if (pv_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff - 1'b1;
               wr_data = rd_data;
            end
            if (!issue && !pv_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cnt_in        = cnt_ff - 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_REMOVED;
               rsp_pay_in    = best_pay_ff;
               rsp_score_in  = best_score_ff;
               rsp_occ_in    = OCC_W'(cnt_ff - 1'b1);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_score_ff, rsp_pay_ff};

endmodule

[hw/rtl/mpql_checker.sv]
// Port-level checker for the max priority queue, bound to the top level.
module mpql_assertions #(
   parameter int DEPTH = mpql_pkg::DEPTH_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mpql_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser
);
   import mpql_pkg::*;

   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   a_no_accept_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result register stalled");

   a_insert_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_INSERT |=>
      rsp_tvalid && (rsp_tuser == STATUS_INSERTED || rsp_tuser == STATUS_FULL))
      else $error("insert did not give its result on the next cycle");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> rsp_tdata[55:48] == DEPTH_OCC)
      else $error("full result with wrong occupancy");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata == '0)
      else $error("empty result with non-zero data");

endmodule

bind max_priority_queue_linear mpql_assertions #(.DEPTH(DEPTH)) u_mpql_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
